### hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

### hw/rtl/b64d_pkg.sv
package b64d_pkg;

   localparam int SEXTET_W = 6;
   localparam int GROUP_W  = 4 * SEXTET_W;
   localparam int UPPER_N  = 26;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_CHAR   = 2'd1;
   localparam logic [1:0] STATUS_BAD_LENGTH = 2'd2;

   // sextet value of each upper-case letter, indexed from 'A'
   localparam logic [SEXTET_W-1:0] UPPER_SEXTET [UPPER_N] = '{
      6'd10, 6'd23, 6'd21, 6'd12, 6'd2,  6'd13, 6'd14, 6'd15, 6'd7,
      6'd16, 6'd17, 6'd18, 6'd25, 6'd24, 6'd8,  6'd9,  6'd0,  6'd3,
      6'd11, 6'd4,  6'd6,  6'd22, 6'd1,  6'd20, 6'd5,  6'd19
   };

   typedef struct packed {
      logic                is_pad;
      logic                is_valid;
      logic [SEXTET_W-1:0] sextet;
   } char_info_type;

endpackage

### hw/rtl/b64d_char_map.sv
module b64d_char_map (
   input  logic [7:0]              char_in,
   output b64d_pkg::char_info_type char_info
);
   import b64d_pkg::*;

   localparam logic [7:0] CHAR_PAD     = 8'h3D;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] LOWER_BASE   = 8'd26;
   localparam logic [7:0] DIGIT_BASE   = 8'd52;

   logic [7:0] upper_off;
   logic [7:0] lower_val;
   logic [7:0] digit_val;

   assign upper_off = char_in - CHAR_UPPER_A;
   assign lower_val = char_in - CHAR_LOWER_A + LOWER_BASE;
   assign digit_val = char_in - CHAR_ZERO + DIGIT_BASE;

   always_comb begin
      char_info = '0;
      if (char_in == CHAR_PAD) begin
         char_info.is_pad = 1'b1;
      end else if (char_in >= CHAR_UPPER_A && char_in <= CHAR_UPPER_Z) begin
         char_info.is_valid = 1'b1;
         char_info.sextet   = UPPER_SEXTET[upper_off[4:0]];
      end else if (char_in >= CHAR_LOWER_A && char_in <= CHAR_LOWER_Z) begin
         char_info.is_valid = 1'b1;
         char_info.sextet   = lower_val[SEXTET_W-1:0];
      end else if (char_in >= CHAR_ZERO && char_in <= CHAR_NINE) begin
         char_info.is_valid = 1'b1;
         char_info.sextet   = digit_val[SEXTET_W-1:0];
      end else if (char_in == CHAR_PLUS) begin
         char_info.is_valid = 1'b1;
         char_info.sextet   = 6'd62;
      end else if (char_in == CHAR_SLASH) begin
         char_info.is_valid = 1'b1;
         char_info.sextet   = 6'd63;
      end
   end

endmodule

### hw/rtl/base64_custom_alphabet_decoder.sv
// Streaming decoder for Base64 over a fixed permuted alphabet. One character
// request is taken per clock; a result for a request appears on the rsp_
// channel in the cycle after acceptance, through a single output register.
// The character lookup and group update fit between the request port and that
// register, so the rate is one character per cycle, and req_ready drops only
// while a result is held and rsp_ready is low. A request that completes a
// group, ends a message or carries a bad character yields one result unless
// discarded; all others yield none. After a bad character the rest of the
// message is discarded up to the request marked last. No warm-up after reset.
`include "assert_macros.svh"

module base64_custom_alphabet_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   input  logic       req_last_char,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_byte_first,
   output logic [7:0] rsp_byte_second,
   output logic [7:0] rsp_byte_third,
   output logic [1:0] rsp_byte_count,
   output logic [1:0] rsp_status,
   output logic       rsp_end_of_message
);
   import b64d_pkg::*;

   localparam logic [2:0] PAD_MAX = 3'd7;

   char_info_type       char_info;
   logic                req_fire;

   logic [GROUP_W-1:0]  group_ff, group_in;
   logic [1:0]          slot_ff, slot_in;
   logic [2:0]          pad_ff, pad_in;
   logic                drop_ff, drop_in;

   logic                rsp_valid_ff;
   logic                emit;
   logic [GROUP_W-1:0]  res_group_ff, res_group_in;
   logic [1:0]          res_count_ff, res_count_in;
   logic [1:0]          res_status_ff, res_status_in;
   logic                res_eom_ff, res_eom_in;

   logic [GROUP_W-1:0]  group_shift;
   logic [2:0]          pad_step;

   b64d_char_map u_char_map (
      .char_in   (req_char_in),
      .char_info (char_info)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign group_shift = {group_ff[GROUP_W-SEXTET_W-1:0], char_info.sextet};
   assign pad_step    = (char_info.is_pad && pad_ff != PAD_MAX) ? pad_ff + 3'd1 : pad_ff;

   always_comb begin
      group_in      = group_ff;
      slot_in       = slot_ff;
      pad_in        = pad_ff;
      drop_in       = drop_ff;
      emit          = 1'b0;
      res_group_in  = '0;
      res_count_in  = 2'd0;
      res_status_in = STATUS_OK;
      res_eom_in    = req_last_char;
      if (drop_ff) begin
         if (req_last_char) begin
            drop_in  = 1'b0;
            group_in = '0;
            slot_in  = 2'd0;
            pad_in   = 3'd0;
         end
      end else if (!char_info.is_pad && !char_info.is_valid) begin
         emit          = 1'b1;
         res_status_in = STATUS_BAD_CHAR;
         group_in      = '0;
         slot_in       = 2'd0;
         pad_in        = 3'd0;
         drop_in       = !req_last_char;
      end else if (slot_ff == 2'd3) begin
         emit          = 1'b1;
         res_group_in  = group_shift;
         res_count_in  = (pad_step == 3'd0) ? 2'd3 : (pad_step == 3'd1) ? 2'd2 : 2'd1;
         group_in      = '0;
         slot_in       = 2'd0;
         pad_in        = 3'd0;
      end else if (req_last_char) begin
         // message ends inside a group
         emit          = 1'b1;
         res_status_in = STATUS_BAD_LENGTH;
         group_in      = '0;
         slot_in       = 2'd0;
         pad_in        = 3'd0;
      end else begin
         group_in = group_shift;
         slot_in  = slot_ff + 2'd1;
         pad_in   = pad_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff     <= '0;
         slot_ff      <= 2'd0;
         pad_ff       <= 3'd0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            group_ff <= group_in;
            slot_ff  <= slot_in;
            pad_ff   <= pad_in;
            drop_ff  <= drop_in;
         end
         if (req_fire && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         res_group_ff  <= res_group_in;
         res_count_ff  <= res_count_in;
         res_status_ff <= res_status_in;
         res_eom_ff    <= res_eom_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_byte_first     = res_group_ff[23:16];
   assign rsp_byte_second    = res_group_ff[15:8];
   assign rsp_byte_third     = res_group_ff[7:0];
   assign rsp_byte_count     = res_count_ff;
   assign rsp_status         = res_status_ff;
   assign rsp_end_of_message = res_eom_ff;

   `ASSERT_IMPLIES(a_err_zero, clock, reset, rsp_valid_ff && res_status_ff != STATUS_OK,
      res_count_ff == 2'd0 && res_group_ff == '0)
   `ASSERT_IMPLIES(a_ok_count, clock, reset, rsp_valid_ff && res_status_ff == STATUS_OK,
      res_count_ff != 2'd0)
   `ASSERT_IMPLIES(a_len_eom, clock, reset, rsp_valid_ff && res_status_ff == STATUS_BAD_LENGTH,
      res_eom_ff)
   `ASSERT_IMPLIES(a_drop_clear, clock, reset, drop_ff,
      slot_ff == 2'd0 && pad_ff == 3'd0 && group_ff == '0)
   `ASSERT_NEXT(a_last_resets, clock, reset, req_fire && req_last_char,
      slot_ff == 2'd0 && !drop_ff)

endmodule
